### rtl/core/gaussian_blur_3x3_rgb_defines.svh
// Assertion macros for the 3x3 RGB blur core.
// Used by gaussian_blur_3x3_rgb.sv; no other dependencies.
`ifndef GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH

// condition holds at every clock edge outside reset
`define GB3_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gb3 invariant violated");

// condition in one cycle implies a condition in the next
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gb3 sequence violated");

`endif

### rtl/core/gb3_pkg.sv
// Shared constants and helper functions for the 3x3 RGB blur core.
// No dependencies.
package gb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int WIN_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int AD_W      = WIN_AW + 1;
    localparam int OFF_W     = $clog2(MAX_WIDTH + 2) + 1;

    localparam int CH_W   = 8;
    localparam int PX_W   = 3 * CH_W;
    localparam int IN_DW  = PX_W;
    localparam int OUT_DW = PX_W;
    localparam int W_W    = 11;
    localparam int H_W    = 16;
    localparam int CFG_DW = H_W;
    localparam int CNT_W  = 26;
    localparam int CNT_XW = CNT_W + 1;
    localparam int SUM_W  = CH_W + 4;
    localparam int WS_W   = 5;
    localparam int TAP_N  = 9;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;
    localparam logic ACT_PUSH       = 1'b0;
    localparam logic ACT_DRAIN      = 1'b1;

    localparam logic [1:0] SH_CORNER = 2'd0;
    localparam logic [1:0] SH_EDGE   = 2'd1;
    localparam logic [1:0] SH_CENTER = 2'd2;

    // one restoring step: shift in the next dividend bit, shift out a quotient bit
    function automatic logic [WS_W+SUM_W-1:0] div_step(
        input logic [WS_W-1:0]  rem,
        input logic [SUM_W-1:0] num,
        input logic [WS_W-1:0]  den
    );
        logic [WS_W:0] t;
        logic          q;
        t = {rem, num[SUM_W-1]};
        q = (t >= {1'b0, den});
        if (q) begin
            t = t - {1'b0, den};
        end
        return {t[WS_W-1:0], num[SUM_W-2:0], q};
    endfunction

    function automatic logic [WIN_AW-1:0] ptr_inc(input logic [WIN_AW-1:0] p);
        return (p == WIN_AW'(WIN_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### rtl/core/gaussian_blur_3x3_rgb.sv
// Top level of the 3x3 binomial RGB blur: window memory, tap sequencer, divider.
// Depends on gb3_pkg, gb3_ram and gaussian_blur_3x3_rgb_defines.svh.
//
// channel   dir  word
// s_axis    in   tdata {blue, green, red}, tuser action (0 push, 1 drain)
// m_axis    out  tdata {blue, green, red}, tlast end of frame
// cfg       in   we / idx / wdata, idx 0 width, idx 1 height
//
// An item without result passes idle, push and check; one with a result also takes
// the tap and divide states and waits in S_OUT on output stall: nine window reads
// through the single read port, then 12-step bit-serial divides, one per channel, in step.
// Reset clears counters and control only; the window is not cleared.
// A finished result waits in the output register while the next word is taken.
`include "gaussian_blur_3x3_rgb_defines.svh"

module gaussian_blur_3x3_rgb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [gb3_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [gb3_pkg::IN_DW-1:0]    i_s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                         i_s_axis_tuser,   // action
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [gb3_pkg::OUT_DW-1:0]   o_m_axis_tdata,   // out_red, out_green, out_blue
    output logic                         o_m_axis_tlast    // frame_last
);
    import gb3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_CHECK,
        S_TAP,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [W_W-1:0]      r_cfg_w;
    logic [H_W-1:0]      r_cfg_h;
    logic [W_W-1:0]      r_w_eff;
    logic [CNT_W-1:0]    r_total;
    logic [CNT_W-1:0]    r_rcv;
    logic [CNT_W-1:0]    r_emt;
    logic [WIN_AW-1:0]   r_wr_ptr;
    logic [WIN_AW-1:0]   r_em_ptr;
    logic                r_act;
    logic [PX_W-1:0]     r_px;
    logic [3:0]          r_tap;
    logic                r_tap_vld;
    logic [1:0]          r_tap_sh;
    logic [SUM_W-1:0]    r_sum_r, r_sum_g, r_sum_b;
    logic [WS_W-1:0]     r_rem_r, r_rem_g, r_rem_b;
    logic [WS_W-1:0]     r_ws;
    logic [3:0]          r_step;
    logic                r_out_vld;
    logic [OUT_DW-1:0]   r_out_data;
    logic                r_out_last;

    logic [W_W-1:0]      w_eff_c;
    logic [H_W-1:0]      h_eff_c;
    logic [W_W+H_W-1:0]  total_c;

    logic                clr;
    logic [CNT_W-1:0]    rcv0, emt0;
    logic [WIN_AW-1:0]   wp0, ep0;
    logic                do_push;
    logic                emit_ok;
    logic                frame_end;
    logic                out_free;

    logic                tap_up, tap_dn, tap_lf, tap_rt;
    logic [1:0]          tap_sh;
    logic [OFF_W-1:0]    w_s, row_off, col_off, tap_off;
    logic [CNT_W+1:0]    tap_q;
    logic                tap_vld;
    logic [AD_W-1:0]     tap_a, tap_fix;

    logic                ram_we;
    logic [PX_W-1:0]     ram_rdata;

    // geometry
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff_c = W_W'(1);
        end else if (r_cfg_w > W_W'(MAX_WIDTH)) begin
            w_eff_c = W_W'(MAX_WIDTH);
        end else begin
            w_eff_c = r_cfg_w;
        end
        h_eff_c = (r_cfg_h == '0) ? H_W'(1) : r_cfg_h;
        total_c = w_eff_c * h_eff_c;
    end

    // frame restart and push
    assign clr     = (r_rcv >= r_total) && (r_emt >= r_rcv);
    assign rcv0    = clr ? '0 : r_rcv;
    assign emt0    = clr ? '0 : r_emt;
    assign wp0     = clr ? '0 : r_wr_ptr;
    assign ep0     = clr ? '0 : r_em_ptr;
    assign do_push = (r_act == ACT_PUSH) && (rcv0 < r_total);
    assign ram_we  = (r_state == S_PUSH) && do_push;

    assign emit_ok = (r_emt < r_rcv) &&
                     (({1'b0, r_rcv} >= {1'b0, r_emt} + CNT_XW'(r_w_eff) + CNT_XW'(2)) ||
                      (r_rcv >= r_total));
    assign frame_end = ({1'b0, r_emt} + CNT_XW'(1)) >= {1'b0, r_total};
    assign out_free  = !r_out_vld || i_m_axis_tready;

    // tap geometry
    always_comb begin
        tap_up = 1'b0;
        tap_dn = 1'b0;
        tap_lf = 1'b0;
        tap_rt = 1'b0;
        tap_sh = SH_CORNER;
        unique case (r_tap)
            4'd0: begin tap_up = 1'b1; tap_lf = 1'b1; end
            4'd1: begin tap_up = 1'b1; tap_sh = SH_EDGE; end
            4'd2: begin tap_up = 1'b1; tap_rt = 1'b1; end
            4'd3: begin tap_lf = 1'b1; tap_sh = SH_EDGE; end
            4'd4: begin tap_sh = SH_CENTER; end
            4'd5: begin tap_rt = 1'b1; tap_sh = SH_EDGE; end
            4'd6: begin tap_dn = 1'b1; tap_lf = 1'b1; end
            4'd7: begin tap_dn = 1'b1; tap_sh = SH_EDGE; end
            4'd8: begin tap_dn = 1'b1; tap_rt = 1'b1; end
            default: begin end
        endcase
    end

    always_comb begin
        w_s     = {{(OFF_W-W_W){1'b0}}, r_w_eff};
        row_off = tap_up ? (~w_s + OFF_W'(1)) : (tap_dn ? w_s : '0);
        col_off = tap_lf ? {OFF_W{1'b1}} : (tap_rt ? OFF_W'(1) : '0);
        tap_off = row_off + col_off;
        tap_q   = {2'b00, r_emt} + {{(CNT_W+2-OFF_W){tap_off[OFF_W-1]}}, tap_off};
        tap_vld = !tap_q[CNT_W+1] && (tap_q[CNT_W:0] < {1'b0, r_total});
        tap_a   = {1'b0, r_em_ptr} + {{(AD_W-OFF_W){tap_off[OFF_W-1]}}, tap_off};
        if (tap_a[AD_W-1]) begin
            tap_fix = tap_a + AD_W'(WIN_DEPTH);
        end else if (tap_a >= AD_W'(WIN_DEPTH)) begin
            tap_fix = tap_a - AD_W'(WIN_DEPTH);
        end else begin
            tap_fix = tap_a;
        end
    end

    gb3_ram #(
        .WIDTH (PX_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wp0),
        .i_wdata (r_px),
        .i_raddr (tap_fix[WIN_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_w   <= W_W'(1024);
            r_cfg_h   <= H_W'(768);
            r_w_eff   <= W_W'(1024);
            r_total   <= CNT_W'(1024 * 768);
            r_rcv     <= '0;
            r_emt     <= '0;
            r_wr_ptr  <= '0;
            r_em_ptr  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_wdata[W_W-1:0];
                    CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_wdata[H_W-1:0];
                endcase
            end
            r_w_eff <= w_eff_c;
            r_total <= total_c[CNT_W-1:0];

            // S_OUT reloads the register itself
            if (r_out_vld && i_m_axis_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_act   <= i_s_axis_tuser;
                        r_px    <= i_s_axis_tdata;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_rcv    <= do_push ? rcv0 + 1'b1 : rcv0;
                    r_wr_ptr <= do_push ? ptr_inc(wp0) : wp0;
                    r_emt    <= emt0;
                    r_em_ptr <= ep0;
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    if (emit_ok) begin
                        r_tap   <= '0;
                        r_ws    <= '0;
                        r_sum_r <= '0;
                        r_sum_g <= '0;
                        r_sum_b <= '0;
                        r_state <= S_TAP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_TAP: begin
                    r_tap_vld <= tap_vld;
                    r_tap_sh  <= tap_sh;
                    if ((r_tap != '0) && r_tap_vld) begin
                        r_ws    <= r_ws + (WS_W'(1) << r_tap_sh);
                        r_sum_r <= r_sum_r + (SUM_W'(ram_rdata[0 +: CH_W]) << r_tap_sh);
                        r_sum_g <= r_sum_g + (SUM_W'(ram_rdata[CH_W +: CH_W]) << r_tap_sh);
                        r_sum_b <= r_sum_b + (SUM_W'(ram_rdata[2*CH_W +: CH_W]) << r_tap_sh);
                    end
                    if (r_tap == 4'(TAP_N)) begin
                        r_step  <= '0;
                        r_rem_r <= '0;
                        r_rem_g <= '0;
                        r_rem_b <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                S_DIV: begin
                    {r_rem_r, r_sum_r} <= div_step(r_rem_r, r_sum_r, r_ws);
                    {r_rem_g, r_sum_g} <= div_step(r_rem_g, r_sum_g, r_ws);
                    {r_rem_b, r_sum_b} <= div_step(r_rem_b, r_sum_b, r_ws);
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'(SUM_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= (r_ws == '0) ? '0 :
                                      {r_sum_b[CH_W-1:0], r_sum_g[CH_W-1:0], r_sum_r[CH_W-1:0]};
                        r_out_last <= frame_end;
                        if (frame_end) begin
                            r_rcv    <= '0;
                            r_emt    <= '0;
                            r_wr_ptr <= '0;
                            r_em_ptr <= '0;
                        end else begin
                            r_emt    <= r_emt + 1'b1;
                            r_em_ptr <= ptr_inc(r_em_ptr);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    `GB3_ASSERT_ALWAYS(a_emt_le_rcv, i_clk, i_rst_n, r_emt <= r_rcv)
    `GB3_ASSERT_ALWAYS(a_ptr_range, i_clk, i_rst_n, (r_wr_ptr < WIN_AW'(WIN_DEPTH)) && (r_em_ptr < WIN_AW'(WIN_DEPTH)))
    `GB3_ASSERT_NEXT(a_accept_push, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_state == S_PUSH)
    `GB3_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && out_free, o_m_axis_tvalid)

endmodule

### rtl/core/gb3_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module gb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2051
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### tb/sv/gaussian_blur_3x3_rgb_tb.sv
// Self-checking testbench for gaussian_blur_3x3_rgb: directed table, then random frames.
// Expected pixels come from the table or a behavioral blur predictor kept in step with each accepted word.
// Depends on gb3_pkg and the blur RTL.
`timescale 1ns / 100ps

module gaussian_blur_3x3_rgb_tb;
    import gb3_pkg::*;

    localparam int unsigned CNT_MASK    = (1 << CNT_W) - 1;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int          IDLE_WAIT   = 40;

    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_blur_px;

    typedef enum logic [1:0] {ROW_PUSH, ROW_DRAIN, ROW_WIDTH, ROW_HEIGHT} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} t_row_chk;

    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] arg;   // tdata word {blue, green, red} or register value
        t_row_chk    chk;
        t_blur_px    want;
    } t_dir_row;

    localparam int DIR_N = 33;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{ROW_PUSH,   24'h8000ff, CHK_NONE,  '0},
        '{ROW_DRAIN,  24'h000000, CHK_NONE,  '0},
        '{ROW_WIDTH,  24'd2047,   CHK_NONE,  '0},
        '{ROW_HEIGHT, 24'd65535,  CHK_NONE,  '0},
        '{ROW_PUSH,   24'h123456, CHK_NONE,  '0},
        '{ROW_WIDTH,  24'd0,      CHK_NONE,  '0},
        '{ROW_HEIGHT, 24'd0,      CHK_NONE,  '0},
        // frame already full: pixel dropped, first pixel comes out alone
        '{ROW_PUSH,   24'h070707, CHK_WORD,  '{1'b1, 8'h80, 8'h00, 8'hff}},
        '{ROW_PUSH,   24'h01ff00, CHK_WORD,  '{1'b1, 8'h01, 8'hff, 8'h00}},
        '{ROW_PUSH,   24'hffffff, CHK_WORD,  '{1'b1, 8'hff, 8'hff, 8'hff}},
        '{ROW_DRAIN,  24'h000000, CHK_NONE,  '0},
        '{ROW_WIDTH,  24'd3,      CHK_NONE,  '0},
        '{ROW_HEIGHT, 24'd2,      CHK_NONE,  '0},
        '{ROW_PUSH,   24'h000000, CHK_MODEL, '0},
        '{ROW_PUSH,   24'hffffff, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h0000ff, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h00ff00, CHK_MODEL, '0},
        '{ROW_PUSH,   24'hff0000, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h7f807f, CHK_MODEL, '0},
        '{ROW_PUSH,   24'haaaaaa, CHK_MODEL, '0},
        '{ROW_DRAIN,  24'h000000, CHK_MODEL, '0},
        '{ROW_DRAIN,  24'h000000, CHK_MODEL, '0},
        '{ROW_DRAIN,  24'h000000, CHK_MODEL, '0},
        '{ROW_DRAIN,  24'h000000, CHK_NONE,  '0},
        '{ROW_WIDTH,  24'd1,      CHK_NONE,  '0},
        '{ROW_HEIGHT, 24'd768,    CHK_NONE,  '0},
        '{ROW_PUSH,   24'hffffff, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h000000, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h55aa55, CHK_MODEL, '0},
        '{ROW_PUSH,   24'hfefefe, CHK_MODEL, '0},
        '{ROW_PUSH,   24'h010101, CHK_MODEL, '0},
        '{ROW_HEIGHT, 24'd1,      CHK_NONE,  '0},
        // emitted index lies past the shrunk frame: no tap counts
        '{ROW_DRAIN,  24'h000000, CHK_WORD,  '{1'b1, 8'h00, 8'h00, 8'h00}}
    };

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic              i_cfg_idx       = 1'b0;
    logic [CFG_DW-1:0] i_cfg_wdata     = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_DW-1:0]  i_s_axis_tdata  = '0;   // in_red, in_green, in_blue
    logic              i_s_axis_tuser  = 1'b0;  // action
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_axis_tdata;         // out_red, out_green, out_blue
    logic              o_m_axis_tlast;         // frame_last

    logic [W_W-1:0]    geo_width  = 11'd1024;
    logic [H_W-1:0]    geo_height = 16'd768;
    logic [PX_W-1:0]   blur_window [WIN_DEPTH];
    int unsigned       frame_recv;
    int unsigned       frame_sent;
    t_blur_px          blur_expected [$];
    int unsigned       work_items;
    int unsigned       mismatch_count;
    int unsigned       stall_cycles;
    int unsigned       src_idle_pct = 17;
    int unsigned       snk_idle_pct = 45;

    gaussian_blur_3x3_rgb dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    function automatic int unsigned geo_w();
        if (geo_width == '0) return 1;
        if (geo_width > MAX_WIDTH) return MAX_WIDTH;
        return geo_width;
    endfunction

    function automatic int unsigned geo_total();
        int unsigned h;
        h = (geo_height == '0) ? 1 : geo_height;
        return geo_w() * h;
    endfunction

    task automatic blur_predict(input logic act, input logic [23:0] word,
                                output bit fired, output t_blur_px px);
        int unsigned w, total, e, k, sr, sg, sb, ws;
        longint      q;
        int          r, c;
        logic [23:0] tap;
        w     = geo_w();
        total = geo_total();
        fired = 1'b0;
        px    = '0;
        if (frame_recv >= total && frame_sent >= frame_recv) begin
            frame_recv = 0;
            frame_sent = 0;
        end
        if (act == ACT_PUSH && frame_recv < total) begin
            blur_window[frame_recv % WIN_DEPTH] = word;
            frame_recv = (frame_recv + 1) & CNT_MASK;
        end
        e = frame_sent;
        if (e < frame_recv &&
            (longint'(frame_recv) >= longint'(e) + longint'(w) + 2 || frame_recv >= total)) begin
            fired = 1'b1;
            sr = 0; sg = 0; sb = 0; ws = 0;
            for (r = -1; r <= 1; r++) begin
                for (c = -1; c <= 1; c++) begin
                    q = longint'(e) + longint'(w) * r + c;
                    if (q >= 0 && q < longint'(total)) begin
                        tap = blur_window[int'(q % WIN_DEPTH)];
                        k   = (r == 0 && c == 0) ? 4 : ((r == 0 || c == 0) ? 2 : 1);
                        sr += tap[7:0] * k;
                        sg += tap[15:8] * k;
                        sb += tap[23:16] * k;
                        ws += k;
                    end
                end
            end
            if (ws != 0) begin
                px.red   = 8'(sr / ws);
                px.green = 8'(sg / ws);
                px.blue  = 8'(sb / ws);
            end
            if (longint'(e) + 1 >= longint'(total)) begin
                px.last    = 1'b1;
                frame_recv = 0;
                frame_sent = 0;
            end else begin
                frame_sent = (e + 1) & CNT_MASK;
            end
        end
    endtask

    task automatic send_word(input logic act, input logic [23:0] word,
                             output bit fired, output t_blur_px px);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = act;
        i_s_axis_tdata  = word;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        work_items++;
        blur_predict(act, word, fired, px);
    endtask

    // registers change only with no word in flight
    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (blur_expected.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_IDX_WIDTH) geo_width = val[W_W-1:0];
        else geo_height = val;
    endtask

    task automatic run_frame(input bit wide);
        bit          fired;
        t_blur_px    px;
        logic        act;
        int unsigned n;
        logic [15:0] wv, hv;
        if (wide) begin
            wv = 16'(100 + $urandom_range(0, 20));
            hv = 16'd2;
        end else begin
            case ($urandom_range(0, 9))
                0: wv = 16'd0;
                1: wv = 16'($urandom_range(13, 48));
                default: wv = 16'($urandom_range(1, 12));
            endcase
            hv = 16'($urandom_range(0, 6));
        end
        cfg_write(CFG_IDX_WIDTH, wv);
        cfg_write(CFG_IDX_HEIGHT, hv);
        if (wide || $urandom_range(0, 9) < 7) begin
            do begin
                if (frame_recv < geo_total())
                    act = ($urandom_range(0, 99) < 8) ? ACT_DRAIN : ACT_PUSH;
                else
                    act = ($urandom_range(0, 99) < 25) ? ACT_PUSH : ACT_DRAIN;
                send_word(act, 24'($urandom()), fired, px);
                if (fired) blur_expected.push_back(px);
            end while (frame_recv != 0 || frame_sent != 0);
        end else begin
            // partial frame, left open for the next geometry
            n = $urandom_range(1, 2 * geo_w() + 4);
            repeat (n) begin
                act = ($urandom_range(0, 9) < 3) ? ACT_DRAIN : ACT_PUSH;
                send_word(act, 24'($urandom()), fired, px);
                if (fired) blur_expected.push_back(px);
            end
        end
    endtask

    always @(posedge i_clk) begin : out_check
        t_blur_px want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (blur_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: data=%h last=%b", o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = blur_expected.pop_front();
                if (o_m_axis_tdata[7:0] !== want.red || o_m_axis_tdata[15:8] !== want.green ||
                    o_m_axis_tdata[23:16] !== want.blue || o_m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                                 want.red, want.green, want.blue, want.last,
                                 o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                                 o_m_axis_tdata[23:16], o_m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        bit       fired;
        t_blur_px px;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_TAB[i];
            case (row.kind)
                ROW_WIDTH:  cfg_write(CFG_IDX_WIDTH, row.arg[15:0]);
                ROW_HEIGHT: cfg_write(CFG_IDX_HEIGHT, row.arg[15:0]);
                default: begin
                    send_word((row.kind == ROW_DRAIN) ? ACT_DRAIN : ACT_PUSH, row.arg, fired, px);
                    if (row.chk == CHK_WORD) blur_expected.push_back(row.want);
                    else if (row.chk == CHK_MODEL && fired) blur_expected.push_back(px);
                end
            endcase
        end

        work_items = 0;
        while (work_items < 450) run_frame(1'b0);
        src_idle_pct = 45;
        snk_idle_pct = 17;
        while (work_items < 900) run_frame(1'b0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (work_items < 1300) run_frame(1'b0);
        // rows far wider than the random ones
        run_frame(1'b1);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (blur_expected.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && blur_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gb3_pkg.sv
rtl/core/gb3_ram.sv
rtl/core/gaussian_blur_3x3_rgb.sv
tb/sv/gaussian_blur_3x3_rgb_tb.sv
